### sv/zsc_pkg.sv
// shared constants, codes and divider handshake types for the z-score standardizer
package zsc_pkg;

  localparam int MAX_ROWS_DEF    = 256;
  localparam int MAX_COLUMNS_DEF = 16;
  localparam int DATA_W          = 32;
  localparam int NUM_W           = 80;
  localparam int SUM_W           = 48;
  localparam int TEST_POS_W      = 12;
  localparam int ADDR_W          = 3;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  localparam logic [1:0] ACT_LOAD     = 2'd0;
  localparam logic [1:0] ACT_FINALIZE = 2'd1;
  localparam logic [1:0] ACT_EMIT     = 2'd2;
  localparam logic [1:0] ACT_TEST     = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NO_ROWS   = 2'd2;
  localparam logic [1:0] ST_NOT_READY = 2'd3;

  localparam logic REG_COLUMN_COUNT  = 1'b0;
  localparam logic REG_MIN_DEVIATION = 1'b1;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

### sv/zsc_if.sv
// valid/ready channel interfaces for input items and results
interface zsc_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic signed [31:0] sample_value;
  modport source (output valid, action, sample_value, input ready);
  modport sink (input valid, action, sample_value, output ready);
endinterface

interface zsc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] scaled_value;
  logic [7:0]         row_index;
  logic [3:0]         column_index;
  logic               last;
  modport source (output valid, status, scaled_value, row_index, column_index, last,
                  input ready);
  modport sink (input valid, status, scaled_value, row_index, column_index, last,
                output ready);
endinterface

### sv/zsc_div.sv
// restoring unsigned divider, one quotient bit per cycle
module zsc_div
  import zsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  numq;
  logic [DATA_W-1:0] den;
  logic [DATA_W-1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [DATA_W:0]   rem_sh;
  logic              fits;

  assign rem_sh = {rem, numq[NUM_W-1]};
  assign fits   = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start && !busy) begin
        numq <= req.num;
        den  <= req.den;
        rem  <= '0;
        cnt  <= CNT_W'(NUM_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem  <= fits ? DATA_W'(rem_sh - {1'b0, den}) : rem_sh[DATA_W-1:0];
        numq <= {numq[NUM_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) busy <= 1'b0;
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = numq;

  a_no_start_busy: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("divider started while busy");
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done held longer than one cycle");
  a_cnt_live: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("divider busy with no steps left");

endmodule

### sv/column_zscore_standardizer.sv
// Column z-score standardizer: training values (signed Q16.16) are loaded row-major into an
// internal store; finalize computes per-column mean and population deviation over the
// complete rows, then emit requests stream the normalized training values and test values
// are normalized as they arrive, all saturated to Q16.16. One 80-bit restoring divider
// (one quotient bit a cycle) is shared by every division. A load result is registered
// through the output state; emit and test results wait on the divider first, and a finalize
// runs a divider pass for the row count, then a mean division, a variance division and an
// integer square root per column.
// The block takes one item at a time; input ready is high only while the sequencer is idle.
module column_zscore_standardizer
  import zsc_pkg::*;
#(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  zsc_in_if.sink            sample,
  zsc_out_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CNW   = $clog2(MAX_COLUMNS + 1);
  localparam int CIW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_OUT      = 5'd1;
  localparam logic [4:0] S_FROWS    = 5'd2;
  localparam logic [4:0] S_FCOLINIT = 5'd3;
  localparam logic [4:0] S_FSUMRD   = 5'd4;
  localparam logic [4:0] S_FSUMACC  = 5'd5;
  localparam logic [4:0] S_FMEANGO  = 5'd6;
  localparam logic [4:0] S_FMEAN    = 5'd7;
  localparam logic [4:0] S_FVRD     = 5'd8;
  localparam logic [4:0] S_FVDIF    = 5'd9;
  localparam logic [4:0] S_FVMUL    = 5'd10;
  localparam logic [4:0] S_FVACC    = 5'd11;
  localparam logic [4:0] S_FVARGO   = 5'd12;
  localparam logic [4:0] S_FVAR     = 5'd13;
  localparam logic [4:0] S_FSQRT    = 5'd14;
  localparam logic [4:0] S_FCOL     = 5'd15;
  localparam logic [4:0] S_ERD      = 5'd16;
  localparam logic [4:0] S_NSTART   = 5'd17;
  localparam logic [4:0] S_NDIV     = 5'd18;

  logic [4:0]  state;
  logic [4:0]  column_count;
  logic [15:0] min_deviation;

  logic [DATA_W-1:0] store [DEPTH];
  logic [AW-1:0]     mem_addr;
  logic signed [31:0] rdata;

  logic [PW-1:0]  load_pos;
  logic           stats_ready;
  logic [PW-1:0]  emit_pos;
  logic [PW-1:0]  used_total;
  logic [CNW-1:0] used_cols;
  logic [RW-1:0]  emit_row;
  logic [CIW-1:0] emit_col;
  logic [TEST_POS_W-1:0] test_pos;
  logic [TEST_POS_W-1:0] test_row;
  logic [CIW-1:0] test_col;

  logic signed [31:0] col_mean [MAX_COLUMNS];
  logic [31:0]        col_div  [MAX_COLUMNS];

  logic [CNW-1:0] fcols;
  logic [RW-1:0]  frows;
  logic [RW-1:0]  r;
  logic [CIW-1:0] c;
  logic signed [SUM_W-1:0] sum;
  logic signed [31:0] cur_mean;
  logic [31:0]  dmag;
  logic [63:0]  sq;
  logic [NUM_W-1:0] acc;
  logic [63:0]  rad;
  logic [63:0]  root;
  logic [63:0]  bitv;
  logic [4:0]   k;

  logic               emit_mode;
  logic [CIW-1:0]     norm_col;
  logic signed [31:0] xval;
  logic               neg;

  logic [1:0]   res_status;
  logic [31:0]  res_scaled;
  logic [7:0]   res_row;
  logic [3:0]   res_col;
  logic         res_last;

  div_req_t dreq;
  div_rsp_t drsp;

  logic accept;
  logic [CNW-1:0] ecols;
  logic [PW-1:0]  load_limit;
  logic signed [31:0] nx;
  logic signed [32:0] ndiff;
  logic [32:0]    nmag;
  logic signed [32:0] vdiff;
  logic [SUM_W-1:0] smag;
  logic [NUM_W-1:0] rows_q;
  logic [63:0]  quot64;
  logic [63:0]  trial;
  logic [31:0]  dev;

  zsc_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // config port
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= 5'd1;
      min_deviation <= 16'd1;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_COLUMN_COUNT:  column_count  <= pwdata[4:0];
        REG_MIN_DEVIATION: min_deviation <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    unique case (paddr[2])
      REG_COLUMN_COUNT:  prdata = {27'd0, column_count};
      REG_MIN_DEVIATION: prdata = {16'd0, min_deviation};
      default:           prdata = '0;
    endcase
  end

  assign ecols = (column_count == 5'd0) ? CNW'(1) :
                 ((32'(column_count) > MAX_COLUMNS) ? CNW'(MAX_COLUMNS) : CNW'(column_count));
  assign load_limit = PW'(MAX_ROWS) * PW'(ecols);

  assign sample.ready = (state == S_IDLE);
  assign accept = sample.valid && sample.ready;

  // training store
  always_ff @(posedge clk) begin
    if (accept && sample.action == ACT_LOAD && load_pos < load_limit)
      store[load_pos[AW-1:0]] <= sample.sample_value;
    rdata <= store[mem_addr];
  end

  // datapath helpers
  assign nx    = emit_mode ? rdata : xval;
  assign ndiff = {nx[31], nx} - {col_mean[norm_col][31], col_mean[norm_col]};
  assign nmag  = ndiff[32] ? -ndiff : ndiff;
  assign vdiff = {rdata[31], rdata} - {cur_mean[31], cur_mean};
  assign smag  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
  assign rows_q = (drsp.quot > NUM_W'(MAX_ROWS)) ? NUM_W'(MAX_ROWS) : drsp.quot;
  assign quot64 = (drsp.quot[NUM_W-1:64] != '0) ? '1 : drsp.quot[63:0];
  assign trial  = root + bitv;
  assign dev    = root[31:0];

  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = '0;
    dreq.den   = '0;
    if (accept && sample.action == ACT_FINALIZE) begin
      dreq.start = 1'b1;
      dreq.num   = NUM_W'(load_pos);
      dreq.den   = 32'(ecols);
    end else if (state == S_FMEANGO) begin
      dreq.start = 1'b1;
      dreq.num   = NUM_W'(smag) + NUM_W'(frows >> 1);
      dreq.den   = 32'(frows);
    end else if (state == S_FVARGO) begin
      dreq.start = 1'b1;
      dreq.num   = acc;
      dreq.den   = 32'(frows);
    end else if (state == S_NSTART) begin
      dreq.start = 1'b1;
      dreq.num   = NUM_W'({nmag[31:0], 16'd0}) + NUM_W'(col_div[norm_col] >> 1);
      dreq.den   = col_div[norm_col];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      load_pos      <= '0;
      stats_ready   <= 1'b0;
      emit_pos      <= '0;
      emit_row      <= '0;
      emit_col      <= '0;
      test_pos      <= '0;
      test_row      <= '0;
      test_col      <= '0;
      used_total    <= '0;
      used_cols     <= '0;
      result.valid  <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_OUT) result.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (sample.action)
              ACT_LOAD: begin
                res_status <= (load_pos >= load_limit) ? ST_FULL : ST_OK;
                res_scaled <= '0;
                res_row    <= '0;
                res_col    <= '0;
                res_last   <= 1'b0;
                if (load_pos < load_limit) begin
                  load_pos    <= load_pos + 1'b1;
                  stats_ready <= 1'b0;
                end
                state <= S_OUT;
              end
              ACT_FINALIZE: begin
                res_scaled <= '0;
                res_row    <= '0;
                res_col    <= '0;
                res_last   <= 1'b0;
                fcols      <= ecols;
                state      <= S_FROWS;
              end
              ACT_EMIT: begin
                if (!stats_ready || emit_pos >= used_total) begin
                  res_status <= ST_NOT_READY;
                  res_scaled <= '0;
                  res_row    <= '0;
                  res_col    <= '0;
                  res_last   <= 1'b0;
                  state      <= S_OUT;
                end else begin
                  res_status <= ST_OK;
                  emit_mode  <= 1'b1;
                  norm_col   <= emit_col;
                  mem_addr   <= emit_pos[AW-1:0];
                  res_row    <= 8'(emit_row);
                  res_col    <= 4'(emit_col);
                  res_last   <= (PW'(emit_pos + 1'b1) == used_total);
                  emit_pos   <= emit_pos + 1'b1;
                  if (CNW'(emit_col) + 1'b1 == used_cols) begin
                    emit_col <= '0;
                    emit_row <= emit_row + 1'b1;
                  end else begin
                    emit_col <= emit_col + 1'b1;
                  end
                  state <= S_ERD;
                end
              end
              ACT_TEST: begin
                res_last <= 1'b0;
                if (!stats_ready) begin
                  res_status <= ST_NOT_READY;
                  res_scaled <= '0;
                  res_row    <= '0;
                  res_col    <= '0;
                  state      <= S_OUT;
                end else begin
                  res_status <= ST_OK;
                  emit_mode  <= 1'b0;
                  norm_col   <= test_col;
                  xval       <= sample.sample_value;
                  res_row    <= 8'(test_row);
                  res_col    <= 4'(test_col);
                  test_pos   <= test_pos + 1'b1;
                  // position counter wraps, so row and column restart with it
                  if (test_pos == '1) begin
                    test_col <= '0;
                    test_row <= '0;
                  end else if (CNW'(test_col) + 1'b1 == used_cols) begin
                    test_col <= '0;
                    test_row <= test_row + 1'b1;
                  end else begin
                    test_col <= test_col + 1'b1;
                  end
                  state <= S_NSTART;
                end
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_OUT: begin
          if (!result.valid || result.ready) begin
            result.valid        <= 1'b1;
            result.status       <= res_status;
            result.scaled_value <= res_scaled;
            result.row_index    <= res_row;
            result.column_index <= res_col;
            result.last         <= res_last;
            state               <= S_IDLE;
          end
        end
        S_FROWS: begin
          if (drsp.done) begin
            if (rows_q == '0) begin
              stats_ready <= 1'b0;
              res_status  <= ST_NO_ROWS;
              state       <= S_OUT;
            end else begin
              frows <= RW'(rows_q);
              c     <= '0;
              state <= S_FCOLINIT;
            end
          end
        end
        S_FCOLINIT: begin
          sum      <= '0;
          r        <= '0;
          mem_addr <= AW'(c);
          state    <= S_FSUMRD;
        end
        S_FSUMRD: state <= S_FSUMACC;
        S_FSUMACC: begin
          sum      <= sum + SUM_W'(rdata);
          r        <= r + 1'b1;
          mem_addr <= AW'(PW'(mem_addr) + PW'(fcols));
          state    <= (RW'(r + 1'b1) == frows) ? S_FMEANGO : S_FSUMRD;
        end
        S_FMEANGO: begin
          neg   <= sum[SUM_W-1];
          state <= S_FMEAN;
        end
        S_FMEAN: begin
          if (drsp.done) begin
            cur_mean <= neg ? -$signed(drsp.quot[31:0]) : $signed(drsp.quot[31:0]);
            acc      <= '0;
            r        <= '0;
            mem_addr <= AW'(c);
            state    <= S_FVRD;
          end
        end
        S_FVRD: state <= S_FVDIF;
        S_FVDIF: begin
          dmag  <= vdiff[32] ? 32'(-vdiff) : 32'(vdiff);
          state <= S_FVMUL;
        end
        S_FVMUL: begin
          sq    <= dmag * dmag;
          state <= S_FVACC;
        end
        S_FVACC: begin
          acc      <= acc + NUM_W'(sq);
          r        <= r + 1'b1;
          mem_addr <= AW'(PW'(mem_addr) + PW'(fcols));
          state    <= (RW'(r + 1'b1) == frows) ? S_FVARGO : S_FVRD;
        end
        S_FVARGO: state <= S_FVAR;
        S_FVAR: begin
          if (drsp.done) begin
            rad   <= quot64;
            root  <= '0;
            bitv  <= 64'h4000_0000_0000_0000;
            k     <= '0;
            state <= S_FSQRT;
          end
        end
        S_FSQRT: begin
          // one bit pair of the integer square root per cycle
          if (rad >= trial) begin
            rad  <= rad - trial;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          k    <= k + 1'b1;
          if (k == 5'd31) state <= S_FCOL;
        end
        S_FCOL: begin
          col_mean[c] <= cur_mean;
          col_div[c]  <= (dev == '0 || dev < {16'd0, min_deviation}) ? ONE_Q16 : dev;
          if (CNW'(c) + 1'b1 == fcols) begin
            used_cols   <= fcols;
            used_total  <= PW'(frows) * PW'(fcols);
            stats_ready <= 1'b1;
            emit_pos    <= '0;
            emit_row    <= '0;
            emit_col    <= '0;
            test_pos    <= '0;
            test_row    <= '0;
            test_col    <= '0;
            res_status  <= ST_OK;
            state       <= S_OUT;
          end else begin
            c     <= c + 1'b1;
            state <= S_FCOLINIT;
          end
        end
        S_ERD: state <= S_NSTART;
        S_NSTART: begin
          neg   <= ndiff[32];
          state <= S_NDIV;
        end
        S_NDIV: begin
          if (drsp.done) begin
            if (!neg) begin
              res_scaled <= (drsp.quot > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
                                                                 : drsp.quot[31:0];
            end else begin
              res_scaled <= (drsp.quot > NUM_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                                        : -drsp.quot[31:0];
            end
            state <= S_OUT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cols_live: assert property (@(posedge clk) disable iff (rst)
    stats_ready |-> used_cols != '0)
    else $error("statistics ready with no columns");
  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    stats_ready |-> emit_pos <= used_total)
    else $error("emit position past training values");
  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    load_pos <= PW'(DEPTH))
    else $error("load position past store depth");

endmodule
